[hw/rtl/ktf_pkg.sv]
// ---------------------------------------------------------------------------
// ktf_pkg: shared definitions of the Kalman trend forecaster
// Number formats, request and register codes, and saturation helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package ktf_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int DW          = 32;
	localparam int VW          = 31;
	localparam int ACC_W       = 52;
	localparam int PROD_W      = 2 * DW - FRAC_BITS;
	localparam int NUM_W       = DW + FRAC_BITS;
	localparam int ROOT_W      = NUM_W / 2;
	localparam int HOR_W       = 7;
	localparam int MAX_HORIZON = 64;
	localparam int DECAY_W     = 16;
	localparam int CFG_IDX_W   = 3;

	typedef enum logic [1:0] {
		REQ_SEED     = 2'd0,
		REQ_MEASURE  = 2'd1,
		REQ_FORECAST = 2'd2,
		REQ_NONE     = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEAS_NOISE  = 3'd0,
		CFG_TREND_DECAY = 3'd1,
		CFG_NOISE_LEVEL = 3'd2,
		CFG_NOISE_TREND = 3'd3,
		CFG_NOISE_ACCEL = 3'd4,
		CFG_START_VAR   = 3'd5
	} cfg_idx_t;

	localparam logic [VW-1:0]      RST_MEAS_NOISE  = 31'd65536;
	localparam logic [DECAY_W-1:0] RST_TREND_DECAY = 16'd16384;
	localparam logic [VW-1:0]      RST_NOISE_LEVEL = 31'd3277;
	localparam logic [VW-1:0]      RST_NOISE_TREND = 31'd19661;
	localparam logic [VW-1:0]      RST_NOISE_ACCEL = 31'd6554;
	localparam logic [VW-1:0]      RST_START_VAR   = 31'd327680;

	typedef logic signed [DW-1:0]    word_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	function automatic acc_t ext_w(input word_t v);
		return {{(ACC_W-DW){v[DW-1]}}, v};
	endfunction

	function automatic word_t sat_w(input acc_t v);
		acc_t hi;
		acc_t lo;
		hi = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
		lo = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
		if (v > hi) return {1'b0, {(DW-1){1'b1}}};
		else if (v < lo) return {1'b1, {(DW-1){1'b0}}};
		else return v[DW-1:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/ktf_div.sv]
// ---------------------------------------------------------------------------
// ktf_div: restoring divider
// Unsigned division, one quotient bit per cycle, done pulse at the end.
// ---------------------------------------------------------------------------
`default_nettype none

module ktf_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ktf_pkg::NUM_W-1:0] dividend,
	input  wire logic [ktf_pkg::VW-1:0]    divisor,
	output logic                           done,
	output logic [ktf_pkg::NUM_W-1:0]      quotient
);
	import ktf_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [VW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      rem_sh;
	logic [VW:0]      rem_sub;

	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (rem_sh >= {1'b0, divisor}) begin
					rem_q <= rem_sub[VW-1:0];
					quo_q <= {quo_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[VW-1:0];
					quo_q <= {quo_q[NUM_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[hw/rtl/ktf_isqrt.sv]
// ---------------------------------------------------------------------------
// ktf_isqrt: digit-by-digit integer square root
// Floor square root, one root bit per cycle, done pulse at the end.
// ---------------------------------------------------------------------------
`default_nettype none

module ktf_isqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ktf_pkg::NUM_W-1:0] radicand,
	output logic                           done,
	output logic [ktf_pkg::ROOT_W-1:0]     root
);
	import ktf_pkg::*;

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [NUM_W-1:0]  n_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  rem_sub;

	assign rem_sh  = {rem_q, n_q[NUM_W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign rem_sub = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q    <= radicand;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CNT_W'(ROOT_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				n_q <= {n_q[NUM_W-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= rem_sub[REM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh[REM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

[hw/rtl/kalman_trend_forecaster.sv]
// A seed loads the state and runs the root only; a measurement runs the predict
// multiplies, three divisions (skipped when the innovation variance is not
// positive), the update multiplies and a root; a forecast runs the predict
// multiplies and a root per step. One item at a time; a result beat that is
// stalled holds the sequencer. Reset loads the register defaults, a zero state
// and the start variance on the covariance diagonal.
// ---------------------------------------------------------------------------
// kalman_trend_forecaster: three-state Kalman filter with damped trend
// Seed, measurement, forecast and read-back requests over one shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module kalman_trend_forecaster (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [ktf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ktf_pkg::VW-1:0]        cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    req_type,
	input  wire logic signed [ktf_pkg::DW-1:0] sample,
	input  wire logic signed [ktf_pkg::DW-1:0] sample_prev,
	input  wire logic signed [ktf_pkg::DW-1:0] sample_prev_two,
	input  wire logic [ktf_pkg::HOR_W-1:0]     horizon,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [ktf_pkg::DW-1:0]      est_value,
	output logic [ktf_pkg::VW-1:0]             est_uncertainty,
	output logic [ktf_pkg::HOR_W-1:0]          step_index,
	output logic                               last
);
	import ktf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PR_X, ST_PR_T, ST_PR_P, ST_UPD_PREP, ST_DIV_START, ST_DIV_WAIT,
		ST_UPD_X, ST_UPD_P, ST_SQ_START, ST_SQ_WAIT, ST_OUT
	} state_t;

	state_t state_q;

	logic [VW-1:0]      meas_noise_q, noise_level_q, noise_trend_q, noise_accel_q;
	logic [VW-1:0]      start_var_q;
	logic [DECAY_W-1:0] decay_q;

	word_t ps_q [3];
	word_t pc_q [9];
	word_t wx_q [3];
	word_t xn_q [3];
	word_t wp_q [9];
	word_t t_q  [9];
	word_t gain_q [3];
	word_t innov_q, s_q, z_q;
	acc_t  acc_q;
	logic  fc_q, neg_q;
	logic [1:0]       i_q, j_q, k_q;
	logic [HOR_W-1:0] h_q, step_q;

	logic             out_valid_q, last_q;
	word_t            val_q;
	logic [VW-1:0]    unc_q;
	logic [HOR_W-1:0] idx_q;

	logic                  div_start, div_done, sq_start, sq_done;
	logic [NUM_W-1:0]      div_num, div_quo, sq_n;
	logic [ROOT_W-1:0]     sq_root;
	word_t                 op_a, op_b;
	logic signed [PROD_W-1:0] prod;
	acc_t                  acc_sum;
	word_t                 s_sum, var_sel, upd_sum;
	logic signed [NUM_W-1:0] num_s;
	logic [HOR_W-1:0]      h_in;

	function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
		return 4'({2'b00, r} * 4'd3 + {2'b00, c});
	endfunction

	function automatic word_t f_el(input logic [1:0] r, input logic [1:0] c,
			input logic [DECAY_W-1:0] d);
		word_t one;
		word_t dd;
		one = word_t'(1) <<< FRAC_BITS;
		dd  = {{(DW-DECAY_W){1'b0}}, d};
		case ({r, c})
			4'b0000: f_el = one;
			4'b0001: f_el = one;
			4'b0010: f_el = one >>> 1;
			4'b0101: f_el = one - dd;
			4'b0110: f_el = one;
			4'b1010: f_el = one - (dd <<< 1);
			default: f_el = '0;
		endcase
	endfunction

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			ST_PR_X: begin
				op_a = f_el(i_q, k_q, decay_q);
				op_b = wx_q[k_q];
			end
			ST_PR_T: begin
				op_a = f_el(i_q, k_q, decay_q);
				op_b = wp_q[idx3(k_q, j_q)];
			end
			ST_PR_P: begin
				op_a = t_q[idx3(i_q, k_q)];
				op_b = f_el(j_q, k_q, decay_q);
			end
			ST_UPD_X: begin
				op_a = gain_q[i_q];
				op_b = innov_q;
			end
			ST_UPD_P: begin
				op_a = gain_q[i_q];
				op_b = wp_q[idx3(2'd0, j_q)];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Product rounded half up, then floor shift.
	always_comb begin
		logic signed [2*DW-1:0] full;
		full = op_a * op_b + (64'sd1 <<< (FRAC_BITS - 1));
		prod = full[2*DW-1:FRAC_BITS];
	end

	assign acc_sum = acc_q + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
	assign upd_sum = sat_w(ext_w(wx_q[i_q]) + acc_sum);
	assign s_sum   = sat_w(ext_w(wp_q[0]) + acc_t'({1'b0, meas_noise_q}));
	assign num_s   = {wp_q[idx3(i_q, 2'd0)], {FRAC_BITS{1'b0}}};
	assign div_num = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
	assign var_sel = fc_q ? wp_q[0] : pc_q[0];
	assign sq_n    = (var_sel > 0) ? {1'b0, var_sel[VW-1:0], {FRAC_BITS{1'b0}}} : '0;
	assign div_start = (state_q == ST_DIV_START);
	assign sq_start  = (state_q == ST_SQ_START);
	assign h_in = (horizon > HOR_W'(MAX_HORIZON)) ? HOR_W'(MAX_HORIZON) : horizon;

	ktf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (s_q[VW-1:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	ktf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_n),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			meas_noise_q  <= RST_MEAS_NOISE;
			decay_q       <= RST_TREND_DECAY;
			noise_level_q <= RST_NOISE_LEVEL;
			noise_trend_q <= RST_NOISE_TREND;
			noise_accel_q <= RST_NOISE_ACCEL;
			start_var_q   <= RST_START_VAR;
			for (int n = 0; n < 3; n++) begin
				ps_q[n]   <= '0;
				wx_q[n]   <= '0;
				xn_q[n]   <= '0;
				gain_q[n] <= '0;
			end
			for (int n = 0; n < 9; n++) begin
				pc_q[n] <= (n % 4 == 0) ? {1'b0, RST_START_VAR} : '0;
				wp_q[n] <= '0;
				t_q[n]  <= '0;
			end
			innov_q     <= '0;
			s_q         <= '0;
			z_q         <= '0;
			acc_q       <= '0;
			fc_q        <= 1'b0;
			neg_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			h_q         <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			val_q       <= '0;
			unc_q       <= '0;
			idx_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MEAS_NOISE:  meas_noise_q  <= cfg_data;
					CFG_TREND_DECAY: decay_q       <= cfg_data[DECAY_W-1:0];
					CFG_NOISE_LEVEL: noise_level_q <= cfg_data;
					CFG_NOISE_TREND: noise_trend_q <= cfg_data;
					CFG_NOISE_ACCEL: noise_accel_q <= cfg_data;
					CFG_START_VAR:   start_var_q   <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						z_q    <= sample;
						h_q    <= h_in;
						step_q <= '0;
						i_q    <= '0;
						j_q    <= '0;
						k_q    <= '0;
						acc_q  <= '0;
						for (int n = 0; n < 3; n++) wx_q[n] <= ps_q[n];
						for (int n = 0; n < 9; n++) wp_q[n] <= pc_q[n];
						case (req_t'(req_type))
							REQ_SEED: begin
								ps_q[0] <= sample;
								ps_q[1] <= sat_w(ext_w(sample) - ext_w(sample_prev));
								ps_q[2] <= sat_w(
									ext_w(sat_w(ext_w(sample) - ext_w(sample_prev)))
									- ext_w(sat_w(ext_w(sample_prev)
									- ext_w(sample_prev_two))));
								for (int n = 0; n < 9; n++)
									pc_q[n] <= (n % 4 == 0) ? {1'b0, start_var_q} : '0;
								fc_q    <= 1'b0;
								state_q <= ST_SQ_START;
							end
							REQ_MEASURE: begin
								fc_q    <= 1'b0;
								state_q <= ST_PR_X;
							end
							REQ_FORECAST: begin
								fc_q    <= 1'b1;
								state_q <= (h_in == '0) ? ST_IDLE : ST_PR_X;
							end
							default: begin
								fc_q    <= 1'b0;
								state_q <= ST_SQ_START;
							end
						endcase
					end
				end
				ST_PR_X: begin
					if (k_q == 2'd2) begin
						xn_q[i_q] <= sat_w(acc_sum);
						acc_q     <= '0;
						k_q       <= '0;
						if (i_q == 2'd2) begin
							i_q     <= '0;
							state_q <= ST_PR_T;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						acc_q <= acc_sum;
						k_q   <= k_q + 1'b1;
					end
				end
				ST_PR_T, ST_PR_P: begin
					if (k_q == 2'd2) begin
						acc_q <= '0;
						k_q   <= '0;
						if (state_q == ST_PR_T) begin
							t_q[idx3(i_q, j_q)] <= sat_w(acc_sum);
						end else if (i_q == j_q) begin
							// Process noise joins the diagonal after the first saturation.
							case (i_q)
								2'd0: wp_q[idx3(i_q, j_q)] <= sat_w(ext_w(sat_w(acc_sum))
									+ acc_t'({1'b0, noise_level_q}));
								2'd1: wp_q[idx3(i_q, j_q)] <= sat_w(ext_w(sat_w(acc_sum))
									+ acc_t'({1'b0, noise_trend_q}));
								default: wp_q[idx3(i_q, j_q)] <= sat_w(
									ext_w(sat_w(acc_sum)) + acc_t'({1'b0, noise_accel_q}));
							endcase
						end else begin
							wp_q[idx3(i_q, j_q)] <= sat_w(acc_sum);
						end
						if (j_q == 2'd2) begin
							j_q <= '0;
							if (i_q == 2'd2) begin
								i_q <= '0;
								if (state_q == ST_PR_T) begin
									state_q <= ST_PR_P;
								end else begin
									wx_q[0] <= xn_q[0][DW-1] ? '0 : xn_q[0];
									wx_q[1] <= xn_q[1];
									wx_q[2] <= xn_q[2];
									step_q  <= step_q + 1'b1;
									state_q <= fc_q ? ST_SQ_START : ST_UPD_PREP;
								end
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						acc_q <= acc_sum;
						k_q   <= k_q + 1'b1;
					end
				end
				ST_UPD_PREP: begin
					innov_q <= sat_w(ext_w(z_q) - ext_w(wx_q[0]));
					s_q     <= s_sum;
					i_q     <= '0;
					j_q     <= '0;
					if (s_sum > 0) begin
						state_q <= ST_DIV_START;
					end else begin
						for (int n = 0; n < 3; n++) gain_q[n] <= '0;
						state_q <= ST_UPD_X;
					end
				end
				ST_DIV_START: begin
					neg_q   <= num_s[NUM_W-1];
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						gain_q[i_q] <= neg_q
							? sat_w(-acc_t'({{(ACC_W-NUM_W){1'b0}}, div_quo}))
							: sat_w(acc_t'({{(ACC_W-NUM_W){1'b0}}, div_quo}));
						if (i_q == 2'd2) begin
							i_q     <= '0;
							state_q <= ST_UPD_X;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_DIV_START;
						end
					end
				end
				ST_UPD_X: begin
					if (i_q == 2'd0) begin
						ps_q[0] <= upd_sum[DW-1] ? '0 : upd_sum;
					end else begin
						ps_q[i_q] <= upd_sum;
					end
					if (i_q == 2'd2) begin
						i_q     <= '0;
						state_q <= ST_UPD_P;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_UPD_P: begin
					pc_q[idx3(i_q, j_q)] <= sat_w(ext_w(wp_q[idx3(i_q, j_q)]) - acc_sum);
					if (j_q == 2'd2) begin
						j_q <= '0;
						if (i_q == 2'd2) begin
							i_q     <= '0;
							state_q <= ST_SQ_START;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_SQ_START: begin
					val_q   <= fc_q ? wx_q[0] : ps_q[0];
					idx_q   <= fc_q ? step_q : '0;
					last_q  <= fc_q ? (step_q == h_q) : 1'b1;
					state_q <= ST_SQ_WAIT;
				end
				ST_SQ_WAIT: begin
					if (sq_done) begin
						unc_q       <= {{(VW-ROOT_W){1'b0}}, sq_root};
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= (fc_q && step_q != h_q) ? ST_PR_X : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall        = (state_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign est_value       = val_q;
	assign est_uncertainty = unc_q;
	assign step_index      = idx_q;
	assign last            = last_q;

endmodule

`default_nettype wire
